// File: hw/rtl/mmt_pkg.sv
package mmt_pkg;

    localparam int AXIS_W = 16;
    localparam int BYTE_W = 8;
    localparam int NUM_AXES = 3;
    localparam int WINDOW_DEPTH_DEF = 10;

    // pipeline enables shared by the three axis lanes
    typedef struct packed {
        logic accept;   // input transaction taken: push window, update sum
        logic adv2;     // load magnitude stage
        logic adv3;     // load product stage
    } lane_ctrl_t;

endpackage

// File: hw/rtl/mmt_lane.sv
module mmt_lane #(
    parameter int WINDOW_DEPTH = mmt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mmt_pkg::lane_ctrl_t               ctrl,
    input  logic signed [mmt_pkg::AXIS_W-1:0] sample,
    output logic signed [mmt_pkg::AXIS_W-1:0] avg
);

    localparam int L_W     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = mmt_pkg::AXIS_W + L_W;
    localparam int SHIFT   = SUM_W + L_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / depth): exact floor division for any magnitude below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    logic signed [mmt_pkg::AXIS_W-1:0] window_reg [WINDOW_DEPTH];
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [SUM_W-1:0]           sum_next;
    logic        [SUM_W-1:0]           mag;
    logic        [SUM_W-1:0]           mag_reg;
    logic                              neg_reg;
    logic        [PROD_W-1:0]          prod_reg;
    logic                              neg3_reg;
    logic        [mmt_pkg::AXIS_W:0]   quot;

    // running sum: add the newest sample, drop the oldest
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(window_reg[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctrl.accept) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[WINDOW_DEPTH-1] <= sample;
            sum_reg <= sum_next;
        end
    end

    always_comb begin
        if (sum_reg[SUM_W-1]) begin
            mag = SUM_W'(-sum_reg);
        end else begin
            mag = SUM_W'(sum_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv2) begin
            mag_reg <= mag;
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv3) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
            neg3_reg <= neg_reg;
        end
    end

    // restore the sign: truncation toward zero
    assign quot = prod_reg[PROD_W-1:SHIFT];

    always_comb begin
        if (neg3_reg) begin
            avg = mmt_pkg::AXIS_W'(-quot);
        end else begin
            avg = quot[mmt_pkg::AXIS_W-1:0];
        end
    end

endmodule

// File: hw/rtl/mmt_merge.sv
module mmt_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  logic signed [mmt_pkg::AXIS_W-1:0] lane_avg [mmt_pkg::NUM_AXES],
    output logic signed [mmt_pkg::AXIS_W-1:0] avg_reg  [mmt_pkg::NUM_AXES],
    output logic signed [mmt_pkg::AXIS_W-1:0] min_reg  [mmt_pkg::NUM_AXES],
    output logic signed [mmt_pkg::AXIS_W-1:0] max_reg  [mmt_pkg::NUM_AXES]
);

    logic signed [mmt_pkg::AXIS_W-1:0] min_next [mmt_pkg::NUM_AXES];
    logic signed [mmt_pkg::AXIS_W-1:0] max_next [mmt_pkg::NUM_AXES];

    always_comb begin
        for (int i = 0; i < mmt_pkg::NUM_AXES; i++) begin
            min_next[i] = (lane_avg[i] < min_reg[i]) ? lane_avg[i] : min_reg[i];
            max_next[i] = (lane_avg[i] > max_reg[i]) ? lane_avg[i] : max_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mmt_pkg::NUM_AXES; i++) begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end else if (load) begin
            for (int i = 0; i < mmt_pkg::NUM_AXES; i++) begin
                min_reg[i] <= min_next[i];
                max_reg[i] <= max_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < mmt_pkg::NUM_AXES; i++) begin
                avg_reg[i] <= lane_avg[i];
            end
        end
    end

endmodule

// File: hw/rtl/magnetometer_average_min_max_tracker_core.sv
// Three-axis magnetometer moving average with running min/max.
// Input stream: one transaction carries one raw sample as six bytes (x, y, z,
// low byte then high byte). The z axis is negated before use.
// Output stream: one transaction per input transaction with the per-axis
// window averages (truncated toward zero) and the smallest and largest
// averages seen since reset.
// Each axis runs in its own lane: window shift line and running sum, then a
// magnitude stage, a reciprocal multiply stage, and a shared output stage that
// tracks min/max for all three axes.
// The result is registered in turn by the running sum, the magnitude, the product
// and the output stage before it is presented on m_tvalid. Throughput: one
// transaction per cycle while the receiver does not stall the output.
// Reset clears the windows, sums, min and max to zero and empties the pipe.
// When the receiver stalls, the held result stays on m_tdata and the stages
// behind it keep filling any empty slots; s_tready drops only once every
// stage holds a result.
module magnetometer_average_min_max_tracker_core #(
    parameter int WINDOW_DEPTH = mmt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [47:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // avg_x, avg_y, avg_z, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [143:0]  m_tdata
);

    localparam int AW = mmt_pkg::AXIS_W;
    localparam int BW = mmt_pkg::BYTE_W;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4;
    mmt_pkg::lane_ctrl_t ctrl;

    logic signed [AW-1:0] sample   [mmt_pkg::NUM_AXES];
    logic signed [AW-1:0] lane_avg [mmt_pkg::NUM_AXES];
    logic signed [AW-1:0] avg_reg  [mmt_pkg::NUM_AXES];
    logic signed [AW-1:0] min_reg  [mmt_pkg::NUM_AXES];
    logic signed [AW-1:0] max_reg  [mmt_pkg::NUM_AXES];
    logic        [AW-1:0] z_raw;

    // each stage advances when it is empty or the stage ahead advances
    assign adv4 = !out_valid_reg || m_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_tready    = adv1;
    assign ctrl.accept = s_tvalid && adv1;
    assign ctrl.adv2   = adv2;
    assign ctrl.adv3   = adv3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
            if (adv4) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    assign z_raw     = {s_tdata[6*BW-1:5*BW], s_tdata[5*BW-1:4*BW]};
    assign sample[0] = {s_tdata[2*BW-1:BW], s_tdata[BW-1:0]};
    assign sample[1] = {s_tdata[4*BW-1:3*BW], s_tdata[3*BW-1:2*BW]};
    assign sample[2] = AW'(-z_raw);   // wraps: the most negative value maps to itself

    for (genvar a = 0; a < mmt_pkg::NUM_AXES; a++) begin : g_lane
        mmt_lane #(
            .WINDOW_DEPTH(WINDOW_DEPTH)
        ) u_lane (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctrl   (ctrl),
            .sample (sample[a]),
            .avg    (lane_avg[a])
        );
    end

    mmt_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (v3_reg && adv4),
        .lane_avg(lane_avg),
        .avg_reg (avg_reg),
        .min_reg (min_reg),
        .max_reg (max_reg)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {max_reg[2], max_reg[1], max_reg[0],
                       min_reg[2], min_reg[1], min_reg[0],
                       avg_reg[2], avg_reg[1], avg_reg[0]};

    // min starts at zero and only falls; max starts at zero and only rises
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (min_reg[0] <= 0) && (min_reg[1] <= 0) && (min_reg[2] <= 0)
                  && (max_reg[0] >= 0) && (max_reg[1] >= 0) && (max_reg[2] >= 0))
        else $error("tracked extremes crossed zero");

    // the presented average always lies inside the tracked range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (min_reg[0] <= avg_reg[0]) && (avg_reg[0] <= max_reg[0])
                  && (min_reg[1] <= avg_reg[1]) && (avg_reg[1] <= max_reg[1])
                  && (min_reg[2] <= avg_reg[2]) && (avg_reg[2] <= max_reg[2]))
        else $error("average outside min/max");

    // input back-pressure only when every stage is occupied and output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && out_valid_reg && !m_tready)
        else $error("input stalled with a free pipeline slot");

    // an accepted sample entering an empty pipeline raises m_tvalid after passing every stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !v1_reg && !v2_reg && !v3_reg && !out_valid_reg)
        |=> ##3 m_tvalid)
        else $error("result lost in pipeline");

endmodule

// File: sim/mmt_result_checker.sv
module mmt_result_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [47:0]   s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    // avg_x, avg_y, avg_z, min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [143:0]  m_tdata,
    output int            mismatch_count,
    output int            pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_W = mmt_pkg::AXIS_W;
    localparam int NUM_AXES = mmt_pkg::NUM_AXES;
    localparam int WINDOW_DEPTH = mmt_pkg::WINDOW_DEPTH_DEF;
    localparam int NUM_FIELDS = 3 * NUM_AXES;

    const string field_names [NUM_FIELDS] = '{
        "avg_x", "avg_y", "avg_z",
        "min_x", "min_y", "min_z",
        "max_x", "max_y", "max_z"
    };

    logic signed [AXIS_W-1:0] axis_window [NUM_AXES][WINDOW_DEPTH];
    logic signed [AXIS_W-1:0] lowest_avg [NUM_AXES];
    logic signed [AXIS_W-1:0] highest_avg [NUM_AXES];
    logic [143:0]             expected_trackers [$];

    // Shift the sample into each axis window, average it and fold the
    // averages into the running extremes.
    function automatic logic [143:0] predict_tracker_result(input logic [47:0] sample);
        logic [AXIS_W-1:0]        raw;
        logic signed [AXIS_W-1:0] value;
        logic signed [AXIS_W-1:0] avg;
        int                       sum;
        logic [143:0]             res;
        res = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            raw = sample[AXIS_W*a +: AXIS_W];
            // z is negated; the most negative value wraps onto itself
            value = (a == NUM_AXES - 1) ? AXIS_W'(16'h0000 - raw) : raw;
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                axis_window[a][i] = axis_window[a][i + 1];
            axis_window[a][WINDOW_DEPTH - 1] = value;
            sum = 0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                sum += int'(axis_window[a][i]);
            avg = AXIS_W'(sum / WINDOW_DEPTH);
            if (avg < lowest_avg[a])
                lowest_avg[a] = avg;
            if (avg > highest_avg[a])
                highest_avg[a] = avg;
            res[AXIS_W*a +: AXIS_W] = avg;
            res[AXIS_W*(NUM_AXES + a) +: AXIS_W] = lowest_avg[a];
            res[AXIS_W*(2*NUM_AXES + a) +: AXIS_W] = highest_avg[a];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [143:0] want;
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < WINDOW_DEPTH; i++)
                    axis_window[a][i] = '0;
                lowest_avg[a] = '0;
                highest_avg[a] = '0;
            end
            expected_trackers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_trackers.size() == 0) begin
                    $error("result transaction with no input pending: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_trackers.pop_front();
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        if (m_tdata[AXIS_W*f +: AXIS_W] !== want[AXIS_W*f +: AXIS_W]) begin
                            $error("%s mismatch: expected %0d, actual %0d", field_names[f],
                                   $signed(want[AXIS_W*f +: AXIS_W]),
                                   $signed(m_tdata[AXIS_W*f +: AXIS_W]));
                            mismatch_count++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_trackers.push_back(predict_tracker_result(s_tdata));
        end
        pending_results = expected_trackers.size();
    end

endmodule

// File: sim/magnetometer_average_min_max_tracker_core_tb.sv
module magnetometer_average_min_max_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 600;
    localparam int NUM_PHASES = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [47:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [143:0]  m_tdata;

    int mismatch_count;
    int pending_results;
    int idle_count = 0;
    int rx_stall = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    always #1 aclk = ~aclk;

    magnetometer_average_min_max_tracker_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mmt_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // full-range, near-zero and extreme axis values
    function automatic logic [15:0] pick_axis_value();
        case ($urandom_range(0, 3))
            0, 1: return 16'($urandom);
            2: return 16'(int'($urandom_range(0, 40)) - 20);
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    4: return 16'h0001;
                    default: return 16'h8001;
                endcase
            end
        endcase
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata <= {16'($urandom), 32'($urandom)};
        end
    endtask

    // present one sample and hold it until the transaction completes
    task automatic drive_sample(input logic [47:0] sample);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(negedge aclk) begin
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else if ($urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            rx_stall = pick_idle_len() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // start-up fill from an all-zero window
        drive_sample(48'h0);
        // fill with the largest x and y; z of -32768 negates onto itself
        repeat (10) drive_sample({16'h8000, 16'h7FFF, 16'h7FFF});
        // swing to the opposite extremes
        repeat (10) drive_sample({16'h7FFF, 16'h8000, 16'h8000});
        // small values of both signs exercise truncation toward zero
        drive_sample({16'h0001, 16'hFFFB, 16'h0007});
        drive_sample({16'hFFFF, 16'h0005, 16'hFFF9});

        // hold off until the pipe has drained
        idle_cycles(1);
        wait (pending_results == 0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            rx_steady = (phase == 0);
            tx_steady = (phase == 0);
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                if (!tx_steady && $urandom_range(0, 99) < 45)
                    idle_cycles(pick_idle_len());
                drive_sample({pick_axis_value(), pick_axis_value(), pick_axis_value()});
            end
            if (phase == 1) begin
                idle_cycles(1);
                wait (pending_results == 0);
            end
        end
        rx_steady = 1'b0;

        idle_cycles(1);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
